// ===== src/segisect_pkg.sv =====
// Shared types and constants for the segment intersection core.
`default_nettype none

package segisect_pkg;

    localparam int IN_W   = 16;  // one coordinate field on the input beat
    localparam int XY_W   = 32;  // Q-format coordinate width on the result side
    localparam int OUTC_W = 2;

    typedef enum logic [OUTC_W-1:0] {
        OUT_HIT      = 2'd0,
        OUT_PARALLEL = 2'd1,
        OUT_MISS     = 2'd2
    } t_outcome;

    typedef struct packed {
        t_outcome          oc;
        logic [XY_W-1:0]   cy;
        logic [XY_W-1:0]   cx;
    } t_res;

endpackage

`default_nettype wire

// ===== src/segment_intersection_core.sv =====
// Segment intersection core: cross products, pipelined restoring divide, clamp.
// Quotient width QB = max(C+F, 32) + 2; the divider adds one stage per quotient bit.
// Throughput: one beat per cycle while the skid is empty; a two-entry output (register plus
//   skid) takes input after a stall until the skid fills, then the whole pipeline holds.
// Reset: synchronous active-low i_rst_n clears all valid bits; payload is not reset.
`default_nettype none

module segment_intersection_core
    import segisect_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_tvalid,
    output      logic                    o_s_tready,
    // ax, ay, bx, by, cx, cy, dx, dy from bit 0 up, 16 bits each, low COORD_BITS used
    input  wire logic [8*IN_W-1:0]       i_s_tdata,
    output      logic                    o_m_tvalid,
    input  wire logic                    i_m_tready,
    // cross_x, cross_y from bit 0 up
    output      logic [2*XY_W-1:0]       o_m_tdata,
    // outcome
    output      logic [OUTC_W-1:0]       o_m_tuser
);

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int DW  = C + 1;          // coordinate difference
    localparam int PW  = 2 * C + 2;      // cross product / den / numerators
    localparam int AW  = 2 * C + 1;      // magnitude of den / numerators
    localparam int BW  = C + 1;          // magnitude of segment delta
    localparam int HL  = C + 1;          // low split of numerator magnitude
    localparam int HH  = AW - HL;        // high split
    localparam int NW  = AW + BW + F;    // scaled dividend
    localparam int QB  = ((C + F) > 32 ? (C + F) : 32) + 2;  // quotient bits
    localparam int HW  = (NW > QB) ? (NW - QB) : 1;
    localparam int XW  = QB + HW;
    localparam int CW  = (HW > AW) ? HW : AW;
    localparam int SMW = QB + 2;

    typedef struct packed {
        logic [AW-1:0] rx;
        logic [AW-1:0] ry;
        logic [QB-1:0] qx;   // dividend bits shift out the top, quotient shifts in below
        logic [QB-1:0] qy;
        logic [AW-1:0] dm;
        logic          negx;
        logic          negy;
        logic          ovfx;
        logic          ovfy;
        logic          par;
        t_outcome      oc;
        logic [C-1:0]  ax;
        logic [C-1:0]  ay;
    } t_dv;

    function automatic logic [AW-1:0] mag_pw(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] n;
        n = v[PW-1] ? -v : v;
        return n[AW-1:0];
    endfunction

    function automatic logic [BW-1:0] mag_dw(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] n;
        n = v[DW-1] ? -v : v;
        return n[BW-1:0];
    endfunction

    function automatic t_dv div_step(input t_dv s);
        t_dv          o;
        logic [AW:0]  sx;
        logic [AW:0]  sy;
        o  = s;
        sx = {s.rx, s.qx[QB-1]};
        sy = {s.ry, s.qy[QB-1]};
        if (sx >= {1'b0, s.dm}) begin
            o.rx = AW'(sx - {1'b0, s.dm});
            o.qx = {s.qx[QB-2:0], 1'b1};
        end else begin
            o.rx = sx[AW-1:0];
            o.qx = {s.qx[QB-2:0], 1'b0};
        end
        if (sy >= {1'b0, s.dm}) begin
            o.ry = AW'(sy - {1'b0, s.dm});
            o.qy = {s.qy[QB-2:0], 1'b1};
        end else begin
            o.ry = sy[AW-1:0];
            o.qy = {s.qy[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [XY_W-1:0] clamp_xy(input logic signed [SMW-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[SMW-1:XY_W-1];
        hi_zeros = ~|v[SMW-1:XY_W-1];
        if (v[SMW-1] && !hi_ones) begin
            return {1'b1, {(XY_W-1){1'b0}}};
        end else if (!v[SMW-1] && !hi_zeros) begin
            return {1'b0, {(XY_W-1){1'b1}}};
        end
        return v[XY_W-1:0];
    endfunction

    logic en;
    logic out_free;

    // stage 1: differences
    logic                 r_v1;
    logic signed [DW-1:0] r1_e1, r1_e2, r1_e3, r1_e4, r1_e5, r1_e6;
    logic [C-1:0]         r1_ax, r1_ay;
    // stage 2: products
    logic                 r_v2;
    logic signed [PW-1:0] r2_da, r2_db, r2_ta, r2_tb, r2_ua, r2_ub;
    logic signed [DW-1:0] r2_e1, r2_e3;
    logic [C-1:0]         r2_ax, r2_ay;
    // stage 3: den, tn, un
    logic                 r_v3;
    logic signed [PW-1:0] r3_den, r3_tn, r3_un;
    logic signed [DW-1:0] r3_e1, r3_e3;
    logic [C-1:0]         r3_ax, r3_ay;
    // stage 4: magnitudes and signs
    logic                 r_v4;
    logic [AW-1:0]        r4_dm, r4_tm, r4_um;
    logic [BW-1:0]        r4_bxm, r4_bym;
    logic                 r4_negx, r4_negy, r4_par;
    logic                 r4_ts, r4_us, r4_ds, r4_tz, r4_uz;
    logic [C-1:0]         r4_ax, r4_ay;
    // stage 5: partial products, range test
    logic                 r_v5;
    logic [HL+BW-1:0]     r5_xl, r5_yl;
    logic [HH+BW-1:0]     r5_xh, r5_yh;
    logic [AW-1:0]        r5_dm;
    logic                 r5_negx, r5_negy, r5_par;
    t_outcome             r5_oc;
    logic [C-1:0]         r5_ax, r5_ay;
    // stage 6: full dividend
    logic                 r_v6;
    logic [NW-1:0]        r6_nx, r6_ny;
    logic [AW-1:0]        r6_dm;
    logic                 r6_negx, r6_negy, r6_par;
    t_outcome             r6_oc;
    logic [C-1:0]         r6_ax, r6_ay;
    // divider
    logic [QB:0]          r_dv_v;
    t_dv                  r_dv [0:QB];
    t_dv                  w_dv_init;
    logic [XW-1:0]        w_xx, w_xy;
    logic [HW-1:0]        w_hx, w_hy;
    // stage R1: rounded, saturated magnitude
    logic                 r_v8;
    logic [QB:0]          r8_qx, r8_qy;
    logic                 r8_negx, r8_negy, r8_par;
    t_outcome             r8_oc;
    logic [C-1:0]         r8_ax, r8_ay;
    logic                 w_rbx, w_rby;
    // stage R2: signed sum
    logic                  r_v9;
    logic signed [SMW-1:0] r9_sx, r9_sy;
    logic                  r9_par;
    t_outcome              r9_oc;
    logic signed [SMW-1:0] w_bx, w_by, w_ox, w_oy;
    // stage R3 and output
    logic r_p_v;
    t_res r_p;
    logic r_out_v;
    t_res r_out;
    logic r_skid_v;
    t_res r_skid;

    logic signed [C-1:0] w_ax, w_ay, w_bxc, w_byc, w_cx, w_cy, w_dx, w_dy;

    // low COORD_BITS of each field, zero-filled when wider than the field
    assign w_ax  = C'(i_s_tdata[0*IN_W +: IN_W]);
    assign w_ay  = C'(i_s_tdata[1*IN_W +: IN_W]);
    assign w_bxc = C'(i_s_tdata[2*IN_W +: IN_W]);
    assign w_byc = C'(i_s_tdata[3*IN_W +: IN_W]);
    assign w_cx  = C'(i_s_tdata[4*IN_W +: IN_W]);
    assign w_cy  = C'(i_s_tdata[5*IN_W +: IN_W]);
    assign w_dx  = C'(i_s_tdata[6*IN_W +: IN_W]);
    assign w_dy  = C'(i_s_tdata[7*IN_W +: IN_W]);

    // pipeline moves whenever the skid entry is free
    assign en         = ~r_skid_v;
    assign out_free   = ~r_out_v | i_m_tready;
    assign o_s_tready = en;

    assign w_xx = XW'(r6_nx);
    assign w_xy = XW'(r6_ny);
    assign w_hx = w_xx[XW-1:QB];
    assign w_hy = w_xy[XW-1:QB];

    always_comb begin
        w_dv_init      = '0;
        w_dv_init.rx   = AW'(w_hx);
        w_dv_init.ry   = AW'(w_hy);
        w_dv_init.qx   = w_xx[QB-1:0];
        w_dv_init.qy   = w_xy[QB-1:0];
        w_dv_init.dm   = r6_dm;
        w_dv_init.negx = r6_negx;
        w_dv_init.negy = r6_negy;
        // quotient would not fit in QB bits: saturate later
        w_dv_init.ovfx = CW'(w_hx) >= CW'(r6_dm);
        w_dv_init.ovfy = CW'(w_hy) >= CW'(r6_dm);
        w_dv_init.par  = r6_par;
        w_dv_init.oc   = r6_oc;
        w_dv_init.ax   = r6_ax;
        w_dv_init.ay   = r6_ay;
    end

    // round half away from zero: 2r >= d
    assign w_rbx = {r_dv[QB].rx, 1'b0} >= {1'b0, r_dv[QB].dm};
    assign w_rby = {r_dv[QB].ry, 1'b0} >= {1'b0, r_dv[QB].dm};

    assign w_bx = $signed({{(SMW-C){r8_ax[C-1]}}, r8_ax}) <<< F;
    assign w_by = $signed({{(SMW-C){r8_ay[C-1]}}, r8_ay}) <<< F;
    assign w_ox = $signed(SMW'(r8_qx));
    assign w_oy = $signed(SMW'(r8_qy));

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_dv_v <= '0;
            r_v8   <= 1'b0;
            r_v9   <= 1'b0;
            r_p_v  <= 1'b0;
        end else if (en) begin
            r_v1   <= i_s_tvalid;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v5   <= r_v4;
            r_v6   <= r_v5;
            r_dv_v <= {r_dv_v[QB-1:0], r_v6};
            r_v8   <= r_dv_v[QB];
            r_v9   <= r_v8;
            r_p_v  <= r_v9;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_e1 <= {w_ax[C-1], w_ax} - {w_bxc[C-1], w_bxc};
            r1_e2 <= {w_cy[C-1], w_cy} - {w_dy[C-1], w_dy};
            r1_e3 <= {w_ay[C-1], w_ay} - {w_byc[C-1], w_byc};
            r1_e4 <= {w_cx[C-1], w_cx} - {w_dx[C-1], w_dx};
            r1_e5 <= {w_ax[C-1], w_ax} - {w_cx[C-1], w_cx};
            r1_e6 <= {w_ay[C-1], w_ay} - {w_cy[C-1], w_cy};
            r1_ax <= w_ax;
            r1_ay <= w_ay;

            r2_da <= r1_e1 * r1_e2;
            r2_db <= r1_e3 * r1_e4;
            r2_ta <= r1_e5 * r1_e2;
            r2_tb <= r1_e6 * r1_e4;
            r2_ua <= r1_e5 * r1_e3;
            r2_ub <= r1_e6 * r1_e1;
            r2_e1 <= r1_e1;
            r2_e3 <= r1_e3;
            r2_ax <= r1_ax;
            r2_ay <= r1_ay;

            r3_den <= r2_da - r2_db;
            r3_tn  <= r2_ta - r2_tb;
            r3_un  <= r2_ua - r2_ub;
            r3_e1  <= r2_e1;
            r3_e3  <= r2_e3;
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;

            // segment delta b-a is -e; its sign is set when e > 0
            r4_dm   <= mag_pw(r3_den);
            r4_tm   <= mag_pw(r3_tn);
            r4_um   <= mag_pw(r3_un);
            r4_bxm  <= mag_dw(r3_e1);
            r4_bym  <= mag_dw(r3_e3);
            r4_negx <= r3_tn[PW-1] ^ r3_den[PW-1] ^ (!r3_e1[DW-1] && (r3_e1 != '0));
            r4_negy <= r3_tn[PW-1] ^ r3_den[PW-1] ^ (!r3_e3[DW-1] && (r3_e3 != '0));
            r4_par  <= (r3_den == '0);
            r4_ts   <= r3_tn[PW-1];
            r4_us   <= r3_un[PW-1];
            r4_ds   <= r3_den[PW-1];
            r4_tz   <= (r3_tn == '0);
            r4_uz   <= (r3_un == '0);
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;

            r5_xl   <= r4_tm[HL-1:0] * r4_bxm;
            r5_xh   <= r4_tm[AW-1:HL] * r4_bxm;
            r5_yl   <= r4_tm[HL-1:0] * r4_bym;
            r5_yh   <= r4_tm[AW-1:HL] * r4_bym;
            r5_dm   <= r4_dm;
            r5_negx <= r4_negx;
            r5_negy <= r4_negy;
            r5_par  <= r4_par;
            // 0 <= t <= 1 and 0 <= u <= 1, sign of den folded in
            if (r4_par) begin
                r5_oc <= OUT_PARALLEL;
            end else if ((r4_tz || ((r4_ts == r4_ds) && (r4_tm <= r4_dm))) &&
                         (r4_uz || ((r4_us == r4_ds) && (r4_um <= r4_dm)))) begin
                r5_oc <= OUT_HIT;
            end else begin
                r5_oc <= OUT_MISS;
            end
            r5_ax <= r4_ax;
            r5_ay <= r4_ay;

            r6_nx   <= ((NW'(r5_xh) << HL) + NW'(r5_xl)) << F;
            r6_ny   <= ((NW'(r5_yh) << HL) + NW'(r5_yl)) << F;
            r6_dm   <= r5_dm;
            r6_negx <= r5_negx;
            r6_negy <= r5_negy;
            r6_par  <= r5_par;
            r6_oc   <= r5_oc;
            r6_ax   <= r5_ax;
            r6_ay   <= r5_ay;

            r_dv[0] <= w_dv_init;
            for (int k = 0; k < QB; k++) begin
                r_dv[k+1] <= div_step(r_dv[k]);
            end

            r8_qx   <= r_dv[QB].ovfx ? {1'b1, {QB{1'b0}}}
                                     : ({1'b0, r_dv[QB].qx} + (QB+1)'(w_rbx));
            r8_qy   <= r_dv[QB].ovfy ? {1'b1, {QB{1'b0}}}
                                     : ({1'b0, r_dv[QB].qy} + (QB+1)'(w_rby));
            r8_negx <= r_dv[QB].negx;
            r8_negy <= r_dv[QB].negy;
            r8_par  <= r_dv[QB].par;
            r8_oc   <= r_dv[QB].oc;
            r8_ax   <= r_dv[QB].ax;
            r8_ay   <= r_dv[QB].ay;

            r9_sx  <= r8_negx ? (w_bx - w_ox) : (w_bx + w_ox);
            r9_sy  <= r8_negy ? (w_by - w_oy) : (w_by + w_oy);
            r9_par <= r8_par;
            r9_oc  <= r8_oc;

            r_p.cx <= r9_par ? '0 : clamp_xy(r9_sx);
            r_p.cy <= r9_par ? '0 : clamp_xy(r9_sy);
            r_p.oc <= r9_oc;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out    <= r_p;
                r_out_v  <= r_p_v;
            end
        end else if (r_p_v && !r_skid_v) begin
            r_skid   <= r_p;
            r_skid_v <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {r_out.cy, r_out.cx};
    assign o_m_tuser  = r_out.oc;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held while output register empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && i_m_tready |=> !r_skid_v)
        else $error("skid entry not drained after output taken");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == OUT_PARALLEL) |-> (o_m_tdata == '0))
        else $error("parallel result with nonzero coordinates");

    a_no_bad_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == OUT_HIT || o_m_tuser == OUT_PARALLEL ||
                        o_m_tuser == OUT_MISS))
        else $error("unused outcome code on output");

endmodule

`default_nettype wire
